// ===== hw/rtl/hca_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hca_pkg
// Types, action codes and digit helpers shared by the HH:MM:SS clock files.
// ---------------------------------------------------------------------------
package hca_pkg;

   localparam logic [2:0] ACTION_FWD   = 3'd0;
   localparam logic [2:0] ACTION_BACK  = 3'd1;
   localparam logic [2:0] ACTION_CHECK = 3'd2;
   localparam logic [2:0] ACTION_CLEAR = 3'd3;
   localparam logic [2:0] ACTION_LOAD  = 3'd4;

   localparam logic [1:0] ALARM_NONE   = 2'd0;
   localparam logic [1:0] ALARM_FULL   = 2'd1;
   localparam logic [1:0] ALARM_HR_MIN = 2'd2;
   localparam logic [1:0] ALARM_HOUR   = 2'd3;

   localparam logic [5:0] MAX_MIN_SEC  = 6'd59;
   localparam logic [5:0] MAX_HOUR_24  = 6'd23;
   localparam logic [5:0] MAX_HOUR_12  = 6'd12;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;

   typedef struct packed {
      logic [2:0] action;
      logic [4:0] hour_in;
      logic [5:0] minute_in;
      logic [5:0] second_in;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [1:0]  alarm_level;
      logic [63:0] display_text;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [1:0] alarm;
   } time_state_type;

   // Tens digit of a value below 64.
   function automatic logic [2:0] tens_digit(input logic [5:0] v);
      logic [2:0] t;
      if (v >= 6'd60)      t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

   // Two ASCII digits, tens in the upper byte.
   function automatic logic [15:0] two_digits(input logic [5:0] v);
      logic [2:0] t;
      logic [5:0] u;
      t = tens_digit(v);
      u = v - (6'(t) * 6'd10);
      return {CHAR_ZERO + {5'd0, t}, CHAR_ZERO + {4'd0, u[3:0]}};
   endfunction

endpackage : hca_pkg
`default_nettype wire

// ===== hw/rtl/hms_clock_with_alarm.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hms_clock_with_alarm
// HH:MM:SS clock with tick up/down, time load and a sticky alarm level.
// ---------------------------------------------------------------------------
// A request transfer shows up as a response after it passes the input
// register, then the result register.
// Throughput: one transfer per cycle while the response side keeps taking
// results; the time update loop in hca_time_unit sets that figure.
// Reset: synchronous, active high; clears time, alarm level, 12-hour mode
// and both valid flags.
module hms_clock_with_alarm (
   input  wire                       clock,
   input  wire                       reset,
   // request channel
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire hca_pkg::req_payload_type req_data,
   // response channel
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output hca_pkg::rsp_payload_type  rsp_data,
   // mode register
   input  wire                       csr_write_enable,
   input  wire                       csr_write_data
);
   import hca_pkg::*;

   // Stage 1: hold the accepted request.
   logic            cmd_valid_ff;
   req_payload_type cmd_ff;
   // Stage 2: result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   logic           mode_ff;
   logic           advance;
   time_state_type state_next;
   logic [63:0]    text_next;

   // Advance the command into the time registers whenever the result
   // register is empty or its contents leave in this same cycle.
   assign advance   = cmd_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new transfer when stage 1 is empty or is draining now.
   assign req_ready = !cmd_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_ready) begin
         cmd_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_data;
      end
   end

   hca_time_unit u_time (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .twelve_hour_mode (mode_ff),
      .cmd              (cmd_ff),
      .state_next       (state_next)
   );

   hca_display u_display (
      .time_value (state_next),
      .text       (text_next)
   );

   // Result shows the time after this command.
   always_comb begin
      rsp_in.hour_out     = state_next.hours;
      rsp_in.minute_out   = state_next.minutes;
      rsp_in.second_out   = state_next.seconds;
      rsp_in.alarm_level  = state_next.alarm;
      rsp_in.display_text = text_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         // drop the result once it has been taken
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : hms_clock_with_alarm
`default_nettype wire

// ===== hw/rtl/hca_time_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hca_time_unit
// Time and alarm registers with the next-state logic for one action.
// ---------------------------------------------------------------------------
module hca_time_unit (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       advance,
   input  wire                       twelve_hour_mode,
   input  wire hca_pkg::req_payload_type cmd,
   output hca_pkg::time_state_type   state_next
);
   import hca_pkg::*;

   time_state_type state_ff;
   time_state_type state_in;

   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;
   logic [4:0] hour_up;
   logic [4:0] hour_down;
   logic [1:0] check_level;

   always_comb begin
      sec_inc  = {1'b0, state_ff.seconds} + 7'd1;
      min_inc  = {1'b0, state_ff.minutes} + 7'd1;
      hour_inc = {1'b0, state_ff.hours} + 6'd1;

      // hour after a carry up
      if (twelve_hour_mode) begin
         hour_up = (hour_inc > MAX_HOUR_12) ? 5'd1 : hour_inc[4:0];
      end else begin
         hour_up = (hour_inc > MAX_HOUR_24) ? 5'd0 : hour_inc[4:0];
      end

      // hour after a borrow down
      if (twelve_hour_mode) begin
         hour_down = (state_ff.hours <= 5'd1) ? 5'd12 : state_ff.hours - 5'd1;
      end else begin
         hour_down = (state_ff.hours == 5'd0) ? 5'd23 : state_ff.hours - 5'd1;
      end

      // most specific match wins; no match keeps the level
      check_level = state_ff.alarm;
      if (state_ff.hours == cmd.hour_in) begin
         check_level = ALARM_HOUR;
         if (state_ff.minutes == cmd.minute_in) begin
            check_level = ALARM_HR_MIN;
            if (state_ff.seconds == cmd.second_in) check_level = ALARM_FULL;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (cmd.action)
         ACTION_FWD: begin
            if (sec_inc > {1'b0, MAX_MIN_SEC}) begin
               state_in.seconds = 6'd0;
               if (min_inc > {1'b0, MAX_MIN_SEC}) begin
                  state_in.minutes = 6'd0;
                  state_in.hours   = hour_up;
               end else begin
                  state_in.minutes = min_inc[5:0];
               end
            end else begin
               state_in.seconds = sec_inc[5:0];
            end
         end
         ACTION_BACK: begin
            if (state_ff.seconds == 6'd0) begin
               state_in.seconds = MAX_MIN_SEC;
               if (state_ff.minutes == 6'd0) begin
                  state_in.minutes = MAX_MIN_SEC;
                  state_in.hours   = hour_down;
               end else begin
                  state_in.minutes = state_ff.minutes - 6'd1;
               end
            end else begin
               state_in.seconds = state_ff.seconds - 6'd1;
            end
         end
         ACTION_CHECK: begin
            state_in.alarm = check_level;
         end
         ACTION_CLEAR: begin
            state_in.alarm = ALARM_NONE;
         end
         ACTION_LOAD: begin
            state_in.hours   = cmd.hour_in;
            state_in.minutes = cmd.minute_in;
            state_in.seconds = cmd.second_in;
            state_in.alarm   = ALARM_NONE;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule : hca_time_unit
`default_nettype wire

// ===== hw/rtl/hca_display.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hca_display
// Renders a time as eight ASCII characters HH:MM:SS.
// ---------------------------------------------------------------------------
module hca_display (
   input  wire hca_pkg::time_state_type time_value,
   output logic [63:0]             text
);
   import hca_pkg::*;

   assign text = {two_digits({1'b0, time_value.hours}), CHAR_COLON,
                  two_digits(time_value.minutes), CHAR_COLON,
                  two_digits(time_value.seconds)};

endmodule : hca_display
`default_nettype wire

// ===== sim/hms_clock_with_alarm_test.sv =====
// ---------------------------------------------------------------------------
// hms_clock_with_alarm_test
// Self-checking bench for the HH:MM:SS clock. A clocked driver offers
// actions from a queue and a clocked monitor takes the responses, both with
// random bursts of idle cycles. A shadow copy of the clock, the alarm level
// and the hour mode predicts every response, and the monitor checks it field
// by field. Directed wrap, borrow and alarm cases in both hour modes come
// first. Random phases follow, with the hour mode rewritten between them.
// ---------------------------------------------------------------------------
module hms_clock_with_alarm_test;
   import hca_pkg::*;

   // Action codes the block has no use for; they must leave everything alone.
   localparam logic [2:0] ACTION_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACTION_SPARE_LAST  = 3'd7;

   localparam int RANDOM_PER_PHASE = 270;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int LONG_HOLD_AT     = 450;   // responses checked before the long hold
   localparam int DRAIN_CYCLES     = 10;    // leave room for the last responses
   localparam int MAX_PRINTED      = 100;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_ready;
   req_payload_type req_data         = '0;
   logic            rsp_valid;
   logic            rsp_ready        = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data   = 1'b0;

   // Actions waiting for the driver, and responses waiting for the monitor.
   req_payload_type queued_actions[$];
   rsp_payload_type predicted_readouts[$];

   // Shadow of the block: time, alarm level and hour mode.
   time_state_type  shadow_time        = '0;
   logic            shadow_twelve_hour = 1'b0;
   time_state_type  last_loaded        = '0;

   logic            bursts_on      = 1'b1;
   logic            long_hold_done = 1'b0;
   int              send_gap       = 0;
   int              hold_left      = 0;
   int unsigned     sent_count     = 0;
   int unsigned     checked_count  = 0;
   int unsigned     alarm_hits     = 0;
   int unsigned     error_count    = 0;

   hms_clock_with_alarm dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // -----------------------------------------------------------------------
   // Shadow clock
   // -----------------------------------------------------------------------

   // Tens digit then units digit in ASCII; tens wraps mod 10 like the units.
   function automatic logic [15:0] ascii_pair(input logic [5:0] v);
      int unsigned tens;
      int unsigned units;
      tens  = (v / 10) % 10;
      units = v % 10;
      return {8'(CHAR_ZERO + tens), 8'(CHAR_ZERO + units)};
   endfunction

   // Advance one second. Out-of-range minutes and seconds still carry and
   // wrap to zero; the hour wraps to 0 or 1 depending on the mode.
   function automatic void tick_forward();
      int s;
      int m;
      int h;
      s = shadow_time.seconds + 1;
      if (s > MAX_MIN_SEC) begin
         s = 0;
         m = shadow_time.minutes + 1;
         if (m > MAX_MIN_SEC) begin
            m = 0;
            h = shadow_time.hours + 1;
            if (shadow_twelve_hour) begin
               if (h > MAX_HOUR_12) h = 1;
            end else begin
               if (h > MAX_HOUR_24) h = 0;
            end
            shadow_time.hours = h[4:0];
         end
         shadow_time.minutes = m[5:0];
      end
      shadow_time.seconds = s[5:0];
   endfunction

   // Step back one second. Only a zero borrows; large values just decrement.
   // In 12-hour mode both hour 1 and hour 0 borrow down to 12.
   function automatic void tick_backward();
      if (shadow_time.seconds == 0) begin
         shadow_time.seconds = MAX_MIN_SEC;
         if (shadow_time.minutes == 0) begin
            shadow_time.minutes = MAX_MIN_SEC;
            if (shadow_twelve_hour) begin
               if (shadow_time.hours <= 1) shadow_time.hours = 5'(MAX_HOUR_12);
               else shadow_time.hours = shadow_time.hours - 5'd1;
            end else begin
               if (shadow_time.hours == 0) shadow_time.hours = 5'(MAX_HOUR_24);
               else shadow_time.hours = shadow_time.hours - 5'd1;
            end
         end else begin
            shadow_time.minutes = shadow_time.minutes - 6'd1;
         end
      end else begin
         shadow_time.seconds = shadow_time.seconds - 6'd1;
      end
   endfunction

   // Apply one accepted action to the shadow and form the response it owes.
   function automatic rsp_payload_type apply_clock_action(input req_payload_type r);
      rsp_payload_type o;
      case (r.action)
         ACTION_FWD:  tick_forward();
         ACTION_BACK: tick_backward();
         ACTION_CHECK: begin
            // Sticky: a miss leaves the level alone, a hit picks the most
            // specific match.
            if (shadow_time.hours == r.hour_in) begin
               shadow_time.alarm = ALARM_HOUR;
               if (shadow_time.minutes == r.minute_in) begin
                  shadow_time.alarm = ALARM_HR_MIN;
                  if (shadow_time.seconds == r.second_in) shadow_time.alarm = ALARM_FULL;
               end
               alarm_hits++;
            end
         end
         ACTION_CLEAR: shadow_time.alarm = ALARM_NONE;
         ACTION_LOAD: begin
            shadow_time.hours   = r.hour_in;
            shadow_time.minutes = r.minute_in;
            shadow_time.seconds = r.second_in;
            shadow_time.alarm   = ALARM_NONE;
         end
         default: ;
      endcase
      o.hour_out     = shadow_time.hours;
      o.minute_out   = shadow_time.minutes;
      o.second_out   = shadow_time.seconds;
      o.alarm_level  = shadow_time.alarm;
      o.display_text = {ascii_pair({1'b0, shadow_time.hours}), CHAR_COLON,
                        ascii_pair(shadow_time.minutes), CHAR_COLON,
                        ascii_pair(shadow_time.seconds)};
      return o;
   endfunction

   // -----------------------------------------------------------------------
   // Checking
   // -----------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_readout(input rsp_payload_type got);
      rsp_payload_type want;
      if (predicted_readouts.size() == 0) begin
         report_mismatch("response with nothing outstanding", got.display_text, '0);
      end else begin
         want = predicted_readouts.pop_front();
         checked_count++;
         if (got.hour_out !== want.hour_out)
            report_mismatch("hour_out", 64'(got.hour_out), 64'(want.hour_out));
         if (got.minute_out !== want.minute_out)
            report_mismatch("minute_out", 64'(got.minute_out), 64'(want.minute_out));
         if (got.second_out !== want.second_out)
            report_mismatch("second_out", 64'(got.second_out), 64'(want.second_out));
         if (got.alarm_level !== want.alarm_level)
            report_mismatch("alarm_level", 64'(got.alarm_level), 64'(want.alarm_level));
         if (got.display_text !== want.display_text)
            report_mismatch("display_text", got.display_text, want.display_text);
      end
   endtask

   // -----------------------------------------------------------------------
   // Driver: predict on each request transfer, then offer the next action.
   // Valid and payload hold until the transfer; gaps only open after one.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_readouts.push_back(apply_clock_action(req_data));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (queued_actions.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= queued_actions.pop_front();
               if (bursts_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Monitor: check each response transfer, then decide on stalling. Once,
   // well into the random part, hold off long enough to back the block up
   // onto its request side.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_readout(rsp_data);
         if (!long_hold_done && checked_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end else if (hold_left == 0 && bursts_on && $urandom_range(0, 6) == 0) begin
            hold_left = $urandom_range(1, 7);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------

   function automatic void queue_action(input logic [2:0] act, input int h, input int m,
                                        input int s);
      req_payload_type r;
      r.action    = act;
      r.hour_in   = 5'(h);
      r.minute_in = 6'(m);
      r.second_in = 6'(s);
      queued_actions.push_back(r);
   endfunction

   // Mostly ticks around loads placed near rollovers, with checks aimed at
   // the last loaded time so every alarm level comes up. The rest is full
   // range noise, including out-of-range fields and spare action codes.
   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned     pick;
      pick        = $urandom_range(0, 99);
      r.hour_in   = 5'($urandom_range(0, 31));
      r.minute_in = 6'($urandom_range(0, 63));
      r.second_in = 6'($urandom_range(0, 63));
      if (pick < 35) begin
         r.action = ACTION_FWD;
      end else if (pick < 60) begin
         r.action = ACTION_BACK;
      end else if (pick < 75) begin
         r.action = ACTION_CHECK;
         if ($urandom_range(0, 3) != 0) r.hour_in = last_loaded.hours;
         if ($urandom_range(0, 4) >= 2) r.minute_in = last_loaded.minutes;
         if ($urandom_range(0, 1) == 0) r.second_in = last_loaded.seconds;
      end else if (pick < 82) begin
         r.action = ACTION_CLEAR;
      end else if (pick < 97) begin
         r.action = ACTION_LOAD;
         if ($urandom_range(0, 3) != 0) begin
            // Land close to a seconds, minutes or hours rollover.
            r.hour_in = shadow_twelve_hour ? 5'($urandom_range(0, 12))
                                           : 5'($urandom_range(0, 23));
            case ($urandom_range(0, 2))
               0:       r.minute_in = MAX_MIN_SEC;
               1:       r.minute_in = 6'd0;
               default: r.minute_in = 6'($urandom_range(0, 59));
            endcase
            if ($urandom_range(0, 1) == 0) r.second_in = MAX_MIN_SEC - 6'($urandom_range(0, 2));
            else r.second_in = 6'($urandom_range(0, 2));
         end
         last_loaded.hours   = r.hour_in;
         last_loaded.minutes = r.minute_in;
         last_loaded.seconds = r.second_in;
      end else begin
         r.action = 3'($urandom_range(ACTION_SPARE_FIRST, ACTION_SPARE_LAST));
      end
      return r;
   endfunction

   // Write the hour mode; only called while nothing is in flight.
   task automatic write_hour_mode(input logic twelve);
      csr_write_enable <= 1'b1;
      csr_write_data   <= twelve;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_twelve_hour = twelve;
   endtask

   // Hold the sender until every queued action has transferred and every
   // response has come back. Sample mid-cycle so the clocked processes have
   // settled.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (queued_actions.size() != 0 || req_valid || predicted_readouts.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      int phase_idx;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 24-hour mode: wraps both ways, the alarm levels, saturated fields
      // and spare action codes.
      write_hour_mode(1'b0);
      queue_action(ACTION_LOAD, 23, 59, 59);
      queue_action(ACTION_FWD, 0, 0, 0);                 // midnight rollover
      queue_action(ACTION_BACK, 31, 63, 63);             // borrow back to 23:59:59
      queue_action(ACTION_LOAD, 12, 34, 56);
      queue_action(ACTION_CHECK, 12, 0, 0);              // hour only
      queue_action(ACTION_CHECK, 12, 34, 0);             // hour and minute
      queue_action(ACTION_CHECK, 12, 34, 56);            // full match
      queue_action(ACTION_CHECK, 5, 6, 7);               // miss keeps the level
      queue_action(ACTION_CLEAR, 0, 0, 0);
      queue_action(ACTION_CHECK, 12, 34, 56);
      queue_action(ACTION_LOAD, 31, 63, 63);             // load clears the level
      queue_action(ACTION_FWD, 0, 0, 0);                 // everything over range wraps
      queue_action(ACTION_LOAD, 31, 63, 63);
      queue_action(ACTION_BACK, 0, 0, 0);                // plain decrement above 59
      queue_action(ACTION_SPARE_FIRST, 31, 63, 63);
      queue_action(ACTION_SPARE_LAST, 0, 0, 0);
      wait_until_idle();

      // 12-hour mode: 12 -> 1 up, 1 -> 12 down, hour 0 and over-range hours.
      write_hour_mode(1'b1);
      queue_action(ACTION_LOAD, 12, 59, 59);
      queue_action(ACTION_FWD, 0, 0, 0);
      queue_action(ACTION_BACK, 0, 0, 0);
      queue_action(ACTION_LOAD, 1, 0, 0);
      queue_action(ACTION_BACK, 0, 0, 0);
      queue_action(ACTION_LOAD, 0, 0, 0);
      queue_action(ACTION_BACK, 0, 0, 0);
      queue_action(ACTION_LOAD, 0, 59, 59);
      queue_action(ACTION_FWD, 0, 0, 0);
      queue_action(ACTION_LOAD, 23, 59, 59);
      queue_action(ACTION_FWD, 0, 0, 0);
      wait_until_idle();

      // Random phases, alternating the hour mode; drop idling in the last.
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         write_hour_mode(phase_idx[0]);
         if (phase_idx == 3) bursts_on = 1'b0;
         repeat (RANDOM_PER_PHASE) queued_actions.push_back(random_request());
         wait_until_idle();
      end

      // Let any stray response surface before judging.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_readouts.size() != 0)
         report_mismatch("responses never returned", 64'(predicted_readouts.size()), '0);
      if (checked_count != sent_count)
         report_mismatch("responses checked", 64'(checked_count), 64'(sent_count));
      $display("covered %0d request transfers in both hour modes, %0d responses checked",
               sent_count, checked_count);
      $display("alarm checks that matched: %0d, mismatches: %0d", alarm_hits, error_count);
      if (error_count == 0) begin
         $display("hms_clock_with_alarm regression: pass");
      end else begin
         $display("hms_clock_with_alarm regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("hms_clock_with_alarm regression: fail");
      $finish;
   end

endmodule
